// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Sizes, status codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 8;
  localparam int DATA_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // apply the captured request to the cell array
  } spq_cmd_t;

endpackage

// File: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing of the sorted priority queue
// Two-state controller: capture a request, then execute it and strobe done.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output spq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   exec;

  assign cmd.load = start && !busy;
  assign cmd.exec = exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      exec  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
            exec  <= 1'b1;
          end
        end
        S_EXEC: begin
          // the datapath registers its result on this edge
          state <= S_IDLE;
          busy  <= 1'b0;
          exec  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          exec  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted cell array of the priority queue
// Each cell compares its key with the new key in parallel; an insert shifts
// the cells behind the insertion point up by one, a remove shifts all down.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  spq_cmd_t             cmd,
  input  logic                 func,
  input  logic [PRIO_BITS-1:0] priority_req,
  input  logic [DATA_BITS-1:0] payload,
  output status_t              status,
  output logic [PRIO_BITS-1:0] out_priority,
  output logic [DATA_BITS-1:0] out_payload,
  output logic [CNT_W-1:0]     occupancy
);

  logic                 req_func;
  logic [PRIO_BITS-1:0] req_prio;
  logic [DATA_BITS-1:0] req_data;

  logic [PRIO_BITS-1:0] slot_prio      [DEPTH];
  logic [DATA_BITS-1:0] slot_data      [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_next [DEPTH];
  logic [DATA_BITS-1:0] slot_data_next [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [DEPTH-1:0]     stays;   // cell holds an entry that stays ahead of the new one
  logic                 is_full;
  logic                 is_empty;

  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign occupancy = count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= func;
      req_prio <= priority_req;
      req_data <= payload;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stays[i] = (CNT_W'(i) < count) && (slot_prio[i] <= req_prio);
    end
  end

  always_comb begin
    count_next = count;
    for (int i = 0; i < DEPTH; i++) begin
      slot_prio_next[i] = slot_prio[i];
      slot_data_next[i] = slot_data[i];
    end
    if (req_func == FUNC_INSERT) begin
      if (!is_full) begin
        count_next = count + CNT_W'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (!stays[i]) begin
            if (i == 0) begin
              slot_prio_next[i] = req_prio;
              slot_data_next[i] = req_data;
            end else if (stays[i-1]) begin
              slot_prio_next[i] = req_prio;
              slot_data_next[i] = req_data;
            end else begin
              slot_prio_next[i] = slot_prio[i-1];
              slot_data_next[i] = slot_data[i-1];
            end
          end
        end
      end
    end else begin
      if (!is_empty) begin
        count_next = count - CNT_W'(1);
        for (int i = 0; i < DEPTH - 1; i++) begin
          slot_prio_next[i] = slot_prio[i+1];
          slot_data_next[i] = slot_data[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_prio[i] <= slot_prio_next[i];
        slot_data[i] <= slot_data_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (req_func == FUNC_INSERT) begin
        status       <= is_full ? ST_FULL : ST_OK;
        out_priority <= '0;
        out_payload  <= '0;
      end else if (is_empty) begin
        status       <= ST_EMPTY;
        out_priority <= '0;
        out_payload  <= '0;
      end else begin
        status       <= ST_OK;
        out_priority <= slot_prio[0];
        out_payload  <= slot_data[0];
      end
    end
  end

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in ascending key order
// Holds up to DEPTH entries sorted by priority; equal keys leave in arrival
// order. A request is taken when start is high and busy is low. Each request
// is captured in the idle state; in the execute state that follows, all cells
// compare and shift in parallel. done pulses for one cycle, the cycle in which
// busy falls, and marks status, out_priority, out_payload and occupancy; the
// receiver cannot stall, so sample the result on that cycle. A new request may
// be started in the cycle done is high, so requests never overlap.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [PRIO_BITS-1:0] priority_req,
  input  logic [DATA_BITS-1:0] payload,
  output logic                 done,
  output status_t              status,
  output logic [PRIO_BITS-1:0] out_priority,
  output logic [DATA_BITS-1:0] out_payload,
  output logic [CNT_W-1:0]     occupancy
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  spq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .priority_req (priority_req),
    .payload      (payload),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding execute cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)) && (out_priority == '0))
    else $error("full reported on a queue that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> (occupancy == '0) && (out_payload == '0))
    else $error("empty reported on a queue that holds entries");
`endif

endmodule

// File: test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// A short table of directed requests covers the empty and full queue, key
// extremes and ties. Random insert/remove bursts follow and drive the queue
// between empty and full. A shadow copy of the sorted array predicts the
// untyped results, typed rows give theirs; each done checks the oldest one.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int WATCHDOG_LIMIT = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_DIRECTED   = 25;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    status_t              status;
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
    logic [CNT_W-1:0]     occ;
  } spq_result_t;

  typedef struct packed {
    logic                 func;
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
    logic                 typed;
    spq_result_t          res;
  } request_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 func = FUNC_INSERT;
  logic [PRIO_BITS-1:0] priority_req = '0;
  logic [DATA_BITS-1:0] payload = '0;
  logic                 busy;
  logic                 done;
  status_t              status;
  logic [PRIO_BITS-1:0] out_priority;
  logic [DATA_BITS-1:0] out_payload;
  logic [CNT_W-1:0]     occupancy;

  // shadow copy of the sorted slot array
  logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
  logic [DATA_BITS-1:0] shadow_data [DEPTH];
  int                   shadow_count = 0;

  spq_result_t pending_results [$];
  int          error_count = 0;
  int          quiet_cycles = 0;

  request_row_t request_table [NUM_DIRECTED] = '{
    '{FUNC_REMOVE, 8'h00, 32'h0000_0000, 1'b1, '{ST_EMPTY, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 8'h00, 32'h0000_0000, 5'd1}},
    '{FUNC_INSERT, 8'h00, 32'h0000_0000, 1'b1, '{ST_OK, 8'h00, 32'h0000_0000, 5'd2}},
    '{FUNC_INSERT, 8'h00, 32'h0000_0001, 1'b1, '{ST_OK, 8'h00, 32'h0000_0000, 5'd3}},
    '{FUNC_REMOVE, 8'hAA, 32'h5555_5555, 1'b1, '{ST_OK, 8'h00, 32'h0000_0000, 5'd2}},
    '{FUNC_REMOVE, 8'h55, 32'hAAAA_AAAA, 1'b1, '{ST_OK, 8'h00, 32'h0000_0001, 5'd1}},
    '{FUNC_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 8'hFF, 32'hFFFF_FFFF, 5'd0}},
    '{FUNC_INSERT, 8'h80, 32'hA5A5_0001, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h7F, 32'h5A5A_0002, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h80, 32'hA5A5_0003, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h01, 32'h5A5A_0004, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'hFE, 32'hFFFF_0005, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h80, 32'h0000_FF06, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h00, 32'h1234_5607, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'hFF, 32'h8000_0008, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h40, 32'h7FFF_FF09, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h80, 32'hCAFE_000A, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h01, 32'h0F0F_000B, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'hC3, 32'hF0F0_000C, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h3C, 32'h3333_000D, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'hFF, 32'hCCCC_000E, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h00, 32'h9999_000F, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h80, 32'h6666_0010, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}},
    '{FUNC_INSERT, 8'h10, 32'hDEAD_BEEF, 1'b1, '{ST_FULL, 8'h00, 32'h0000_0000, 5'd16}},
    '{FUNC_REMOVE, 8'h00, 32'h0000_0000, 1'b0, '{ST_OK, 8'h00, 32'h0000_0000, 5'd0}}
  };

  sorted_priority_queue dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .priority_req (priority_req),
    .payload      (payload),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Apply one request to the shadow array and return the result it yields.
  function automatic spq_result_t queue_step(logic f, logic [PRIO_BITS-1:0] pr,
                                             logic [DATA_BITS-1:0] dat);
    spq_result_t r;
    int          pos;
    r.status = ST_OK;
    r.prio   = '0;
    r.data   = '0;
    if (f == FUNC_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // go behind every entry with an equal or smaller key
        while (pos < shadow_count && shadow_prio[pos] <= pr) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_prio[k] = shadow_prio[k-1];
          shadow_data[k] = shadow_data[k-1];
        end
        shadow_prio[pos] = pr;
        shadow_data[pos] = dat;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.prio = shadow_prio[0];
        r.data = shadow_data[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_prio[k-1] = shadow_prio[k];
          shadow_data[k-1] = shadow_data[k];
        end
        shadow_count--;
      end
    end
    r.occ = CNT_W'(shadow_count);
    return r;
  endfunction

  // Hold the request until the transaction is taken, then queue its result.
  task automatic send_request(logic f, logic [PRIO_BITS-1:0] pr, logic [DATA_BITS-1:0] dat,
                              logic typed, spq_result_t typed_res);
    spq_result_t predicted;
    start        <= 1'b1;
    func         <= f;
    priority_req <= pr;
    payload      <= dat;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = queue_step(f, pr, dat);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic sender_pause(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [PRIO_BITS-1:0] pick_priority();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_BITS'($urandom_range(3));
      default: return PRIO_BITS'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    spq_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_priority !== want.prio) report_mismatch("out_priority", out_priority, want.prio);
        if (out_payload !== want.data) report_mismatch("out_payload", out_payload, want.data);
        if (occupancy !== want.occ) report_mismatch("occupancy", occupancy, want.occ);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL sorted_priority_queue");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          idle_pct;
    int          burst_left;
    int          insert_bias;
    logic        f;
    spq_result_t no_res;
    no_res      = '0;
    burst_left  = 0;
    insert_bias = 50;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(request_table[i].func, request_table[i].prio, request_table[i].data,
                   request_table[i].typed, request_table[i].res);
      sender_pause(25);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 45 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // bursts that lean to inserts or removes sweep between empty and full
        if (burst_left == 0) begin
          case ($urandom_range(2))
            0:       insert_bias = 75;
            1:       insert_bias = 25;
            default: insert_bias = 50;
          endcase
          burst_left = $urandom_range(10, 40);
        end
        burst_left--;
        f = ($urandom_range(99) < insert_bias) ? FUNC_INSERT : FUNC_REMOVE;
        send_request(f, pick_priority(), DATA_BITS'($urandom), 1'b0, no_res);
        sender_pause(idle_pct);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
